@@ hw/rtl/insertion_sorter_assert.svh @@
// assertion macros for the insertion sorter
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define IS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define IS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/isort_pkg.sv @@
package isort_pkg;

  // width of the key ports
  localparam int unsigned KEY_W = 64;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } isort_state_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic load;
    logic shift;
  } isort_ctrl_t;

endpackage

@@ hw/rtl/isort_cell.sv @@
module isort_cell #(
  parameter int unsigned KEY_W = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  isort_pkg::isort_ctrl_t ctrl_i,
  input  logic [KEY_W-1:0]     new_key_i,
  input  logic [KEY_W-1:0]     left_key_i,
  input  logic                 left_gt_i,
  input  logic                 left_valid_i,
  input  logic [KEY_W-1:0]     right_key_i,
  input  logic                 right_valid_i,
  output logic [KEY_W-1:0]     key_o,
  output logic                 valid_o,
  output logic                 gt_o
);
  import isort_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic             valid_q, valid_d;
  logic             gt;

  // strict compare keeps equal keys in arrival order
  assign gt = valid_q && (key_q > new_key_i);

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.load) begin
      if (left_gt_i) begin
        key_d   = left_key_i;
        valid_d = 1'b1;
      end else if (left_valid_i && (gt || !valid_q)) begin
        key_d   = new_key_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;
  assign gt_o    = gt;

endmodule

@@ hw/rtl/insertion_sorter.sv @@
// channel | handshake              | payload
// --------+------------------------+----------------------------------------
// in      | in_valid_i, in_stall_o | key_i, last_i
// out     | out_valid_o,out_stall_i| sorted_key_o, end_of_set_o, overflow_o
//
// loading takes one key per cycle; each key is placed in the cell row in
// the cycle it is taken, unless the row is full and the key is dropped.
// after the last key the row shifts toward cell 0, one result per cycle
// while the output is not stalled; input is stalled while draining.
// reset empties the row and clears the overflow flag at once.
// output stalls freeze the row; results are never dropped.
module insertion_sorter #(
  parameter int unsigned MAX_ITEMS = 32,
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [isort_pkg::KEY_W-1:0] key_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [isort_pkg::KEY_W-1:0] sorted_key_o,
  output logic                        end_of_set_o,
  output logic                        overflow_o
);
  import isort_pkg::*;
  `include "insertion_sorter_assert.svh"

  localparam int unsigned CKW = 8 * KEY_BYTES;

  isort_state_e   state_q, state_d;
  isort_ctrl_t    ctrl;
  logic           dropped_q, dropped_d;
  logic           in_acc, out_acc, full;
  logic [CKW-1:0] new_key;

  logic [CKW-1:0]       cell_key [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] cell_valid;
  logic [MAX_ITEMS-1:0] cell_gt;
  logic [MAX_ITEMS:0]   fill_plus;

  assign new_key = key_i[CKW-1:0];
  assign full    = cell_valid[MAX_ITEMS-1];
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  if (in_acc && last_i) state_d = ST_DRAIN;
      ST_DRAIN: if (out_acc && end_of_set_o) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b0;
    out_valid_o = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.shift  = 1'b0;
    case (state_q)
      ST_LOAD: begin
        // input is never stalled while loading
        ctrl.load = in_valid_i && !full;
      end
      ST_DRAIN: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b1;
        ctrl.shift  = !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    dropped_d = dropped_q;
    if (in_acc && full) begin
      dropped_d = 1'b1;
    end else if (out_acc && end_of_set_o) begin
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dropped_q <= dropped_d;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic [CKW-1:0] left_key, right_key;
    logic           left_gt, left_valid, right_valid;

    if (i == 0) begin : g_head
      assign left_key   = '0;
      assign left_gt    = 1'b0;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_key   = cell_key[i-1];
      assign left_gt    = cell_gt[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_key   = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_key   = cell_key[i+1];
      assign right_valid = cell_valid[i+1];
    end

    isort_cell #(
      .KEY_W(CKW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_key_i    (new_key),
      .left_key_i   (left_key),
      .left_gt_i    (left_gt),
      .left_valid_i (left_valid),
      .right_key_i  (right_key),
      .right_valid_i(right_valid),
      .key_o        (cell_key[i]),
      .valid_o      (cell_valid[i]),
      .gt_o         (cell_gt[i])
    );
  end

  assign sorted_key_o = KEY_W'(cell_key[0]);
  assign end_of_set_o = !cell_valid[1];
  assign overflow_o   = dropped_q;

  // occupied cells always form a run starting at cell 0
  assign fill_plus = {1'b0, cell_valid} + {{MAX_ITEMS{1'b0}}, 1'b1};

  `IS_ASSERT_NOW(a_head_valid, state_q == ST_DRAIN, cell_valid[0], "drain with empty head cell")
  `IS_ASSERT_NOW(a_packed_row, 1'b1, $onehot(fill_plus), "gap in occupied cells")
  `IS_ASSERT_NEXT(a_drain_goes_on, out_acc && !end_of_set_o, out_valid_o, "set ended early")
  `IS_ASSERT_NEXT(a_drop_flag, in_acc && full, overflow_o, "dropped key not flagged")

endmodule

@@ dv/insertion_sorter_test.sv @@
`timescale 1ns / 100ps

module insertion_sorter_test;

  localparam int unsigned MAX_ITEMS = 32;
  localparam int unsigned KEY_BYTES = 8;
  localparam int unsigned KEY_W = isort_pkg::KEY_W;
  localparam int CLK_HALF = 10;
  localparam int TIMEOUT_NS = 4_000_000;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int N_PHASES = 4;
  localparam int N_DIRECTED = 20;
  localparam int LONG_HOLD = 300;

  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [KEY_W-1:0] KEY_MSB = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] KEY_BELOW_MSB = 64'h7fff_ffff_ffff_ffff;
  // zero padded strings, first character in the top byte
  localparam logic [KEY_W-1:0] STR_B = 64'h6200_0000_0000_0000;
  localparam logic [KEY_W-1:0] STR_APP = 64'h6170_7000_0000_0000;
  localparam logic [KEY_W-1:0] STR_APPLE = 64'h6170_706c_6500_0000;
  localparam logic [KEY_W-1:0] STR_BB = 64'h4242_0000_0000_0000;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             end_of_set;
    logic             overflow;
  } sorted_result_t;

  // one entry per offered key; typed rows carry their single result
  typedef struct packed {
    logic             typed;
    logic [KEY_W-1:0] key;
    logic             overflow;
  } key_check_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
    logic             typed;
    logic [KEY_W-1:0] exp_key;
    logic             exp_ovf;
  } directed_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [KEY_W-1:0] key_i;
  logic             last_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [KEY_W-1:0] sorted_key_o;
  logic             end_of_set_o;
  logic             overflow_o;

  insertion_sorter #(
    .MAX_ITEMS(MAX_ITEMS),
    .KEY_BYTES(KEY_BYTES)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_i       (key_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sorted_key_o(sorted_key_o),
    .end_of_set_o(end_of_set_o),
    .overflow_o  (overflow_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  directed_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{64'h0,         1'b1, 1'b1, 64'h0,      1'b0},
    '{KEY_ONES,      1'b1, 1'b1, KEY_ONES,   1'b0},
    '{KEY_MSB,       1'b1, 1'b1, KEY_MSB,    1'b0},
    '{64'h1,         1'b1, 1'b1, 64'h1,      1'b0},
    // lexicographic order of padded strings, with a duplicate
    '{STR_B,         1'b0, 1'b0, 64'h0,      1'b0},
    '{STR_APPLE,     1'b0, 1'b0, 64'h0,      1'b0},
    '{STR_APP,       1'b0, 1'b0, 64'h0,      1'b0},
    '{STR_APPLE,     1'b0, 1'b0, 64'h0,      1'b0},
    '{64'h0,         1'b0, 1'b0, 64'h0,      1'b0},
    '{KEY_ONES,      1'b1, 1'b0, 64'h0,      1'b0},
    // strictly descending arrival
    '{KEY_ONES,      1'b0, 1'b0, 64'h0,      1'b0},
    '{KEY_MSB,       1'b0, 1'b0, 64'h0,      1'b0},
    '{KEY_BELOW_MSB, 1'b0, 1'b0, 64'h0,      1'b0},
    '{64'h1,         1'b0, 1'b0, 64'h0,      1'b0},
    '{64'h0,         1'b1, 1'b0, 64'h0,      1'b0},
    // all equal
    '{STR_BB,        1'b0, 1'b0, 64'h0,      1'b0},
    '{STR_BB,        1'b0, 1'b0, 64'h0,      1'b0},
    '{STR_BB,        1'b1, 1'b0, 64'h0,      1'b0},
    '{KEY_MSB,       1'b0, 1'b0, 64'h0,      1'b0},
    '{KEY_BELOW_MSB, 1'b1, 1'b0, 64'h0,      1'b0}
  };

  // predictor state
  logic [KEY_W-1:0] held_keys [$];
  logic             keys_dropped;
  sorted_result_t   pending_sorted_q [$];
  key_check_t       offered_q [$];

  int mismatch_count;
  int keys_taken;
  int sets_closed;
  int overflow_sets;
  int results_checked;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;

  function automatic logic [KEY_W-1:0] key_mask();
    if (KEY_BYTES >= 8) return '1;
    return (64'd1 << (8 * KEY_BYTES)) - 64'd1;
  endfunction

  // stable insert, and on a last key release the whole set in order
  task automatic insert_and_release(input logic [KEY_W-1:0] raw_key, input logic is_last);
    logic [KEY_W-1:0] k;
    int               pos;
    sorted_result_t   r;
    k = raw_key & key_mask();
    if (held_keys.size() < MAX_ITEMS) begin
      pos = held_keys.size();
      while (pos > 0 && held_keys[pos-1] > k) pos--;
      held_keys.insert(pos, k);
    end else begin
      keys_dropped = 1'b1;
    end
    if (is_last) begin
      for (int i = 0; i < held_keys.size(); i++) begin
        r.key        = held_keys[i];
        r.end_of_set = (i == held_keys.size() - 1);
        r.overflow   = keys_dropped;
        pending_sorted_q.insert(pending_sorted_q.size(), r);
      end
      sets_closed++;
      if (keys_dropped) overflow_sets++;
      held_keys.delete();
      keys_dropped = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    key_check_t     chk;
    sorted_result_t want;
    sorted_result_t got;
    int             before_n;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        chk = offered_q.pop_front();
        before_n = pending_sorted_q.size();
        insert_and_release(key_i, last_i);
        keys_taken++;
        if (chk.typed) begin
          while (pending_sorted_q.size() > before_n) void'(pending_sorted_q.pop_back());
          want.key        = chk.key;
          want.end_of_set = 1'b1;
          want.overflow   = chk.overflow;
          pending_sorted_q.insert(pending_sorted_q.size(), want);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        got.key        = sorted_key_o;
        got.end_of_set = end_of_set_o;
        got.overflow   = overflow_o;
        if (pending_sorted_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: expected none actual key %h eos %b ovf %b",
                   $time, got.key, got.end_of_set, got.overflow);
        end else begin
          want = pending_sorted_q.pop_front();
          results_checked++;
          if (got.key !== want.key) begin
            mismatch_count++;
            $display("%0t: sorted_key mismatch: expected %h actual %h",
                     $time, want.key, got.key);
          end
          if (got.end_of_set !== want.end_of_set) begin
            mismatch_count++;
            $display("%0t: end_of_set mismatch: expected %b actual %b",
                     $time, want.end_of_set, got.end_of_set);
          end
          if (got.overflow !== want.overflow) begin
            mismatch_count++;
            $display("%0t: overflow mismatch: expected %b actual %b",
                     $time, want.overflow, got.overflow);
          end
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results outstanding", $time, pending_sorted_q.size());
    $display("FAILURE");
    $finish;
  end

  function automatic logic [KEY_W-1:0] make_key();
    logic [KEY_W-1:0] k;
    int               n;
    k = '0;
    case ($urandom_range(3))
      0: k = {$urandom, $urandom};
      1: begin
        // narrow pool so equal keys show up often
        k = {56'h0, 8'($urandom_range(3))} << (8 * $urandom_range(7));
      end
      2: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) k[KEY_W-1-8*i -: 8] = 8'($urandom_range(8'h20, 8'h7e));
      end
      default: begin
        case ($urandom_range(3))
          0: k = '0;
          1: k = KEY_ONES;
          2: k = KEY_MSB;
          default: k = KEY_BELOW_MSB;
        endcase
      end
    endcase
    return k;
  endfunction

  // offer one key and hold it until the transfer happens
  task automatic send_key(input logic [KEY_W-1:0] k, input logic lst, input key_check_t chk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    offered_q.insert(offered_q.size(), chk);
    in_valid_i <= 1'b1;
    key_i      <= k;
    last_i     <= lst;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_key(make_key(), (i == n - 1), '0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_sorted_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int         phase_keys;
    int         n;
    int         r;
    key_check_t chk;
    mismatch_count = 0;
    keys_taken = 0;
    sets_closed = 0;
    overflow_sets = 0;
    results_checked = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    keys_dropped = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    key_i      <= '0;
    last_i     <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      chk.typed    = directed_rows[i].typed;
      chk.key      = directed_rows[i].exp_key;
      chk.overflow = directed_rows[i].exp_ovf;
      send_key(directed_rows[i].key, directed_rows[i].last, chk);
    end
    // store exactly full, then full with keys dropped including the last one
    send_set(MAX_ITEMS);
    send_set(MAX_ITEMS + 3);
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      // long receiver hold-off while the sender keeps offering keys
      if (ph == 0 || ph == 3) hold_request = LONG_HOLD;
      phase_keys = 0;
      while (phase_keys < ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 70) n = $urandom_range(1, 6);
        else if (r < 90) n = $urandom_range(7, MAX_ITEMS);
        else n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
        send_set(n);
        phase_keys += n;
        if ($urandom_range(9) == 0) wait_drained();
      end
      wait_drained();
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (2 * MAX_ITEMS + 10) @(posedge clk_i);
    if (pending_sorted_q.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_sorted_q.size());
    end
    $display("run covered %0d keys in %0d sets (%0d with dropped keys), %0d results checked",
             keys_taken, sets_closed, overflow_sets, results_checked);
    $display("idle mixes: none, sender 45%%, receiver 45%%, both 23%%, plus long hold-offs");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
